// ----- design/scma_pkg.sv -----
// Package: shared constants, action codes and control/status types for the COO adder.
`timescale 1ns / 1ps
`default_nettype none
package scma_pkg;

  localparam int DEPTH      = 32;
  localparam int INDEX_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = VAL_W + 1;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_MERGE  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic [VAL_W-1:0]      value;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic clr;
    logic start;
    logic step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/scma_if.sv -----
// Interfaces: input word channel and result word channel with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface scma_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        row;
  logic [15:0]        col;
  logic signed [15:0] value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface scma_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_row;
  logic [15:0]        out_col;
  logic signed [16:0] out_value;
  logic               last;
  logic               empty_res;
  logic               overflow;

  modport source (output valid, out_row, out_col, out_value, last, empty_res, overflow,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, empty_res, overflow,
                  output ready);
endinterface
`default_nettype wire

// ----- design/scma_dp.sv -----
// Datapath: the two coordinate stores, counts, merge walk indices and result register.
`timescale 1ns / 1ps
`default_nettype none
module scma_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire scma_pkg::cmd_t      cmd_i,
  input  wire logic [15:0]         row_i,
  input  wire logic [15:0]         col_i,
  input  wire logic [15:0]         value_i,
  output      scma_pkg::sts_t      sts_o,
  output      logic [15:0]         out_row_o,
  output      logic [15:0]         out_col_o,
  output      logic signed [16:0]  out_value_o,
  output      logic                last_o,
  output      logic                empty_res_o,
  output      logic                overflow_o
);
  import scma_pkg::*;

  entry_t mem_a [DEPTH];
  entry_t mem_b [DEPTH];
  entry_t rd_a_q, rd_b_q;
  entry_t wr_entry;

  logic [CNT_W-1:0] cnt_a_q, cnt_b_q, i_q, j_q, i_d, j_d;
  logic             ovf_q;
  logic             full_a, full_b;

  logic a_av, b_av, row_lt, row_eq, col_lt, col_eq;
  logic a_first, b_first, both, take_a, take_b, pick_last;
  logic [CNT_W-1:0] i_nxt, j_nxt;
  logic [SUM_W-1:0] pick_val;
  entry_t           pick;

  logic [15:0]        out_row_q, out_col_q;
  logic [SUM_W-1:0]   out_val_q;
  logic               last_q, empty_q, out_ovf_q;

  assign full_a = (cnt_a_q >= CNT_W'(DEPTH));
  assign full_b = (cnt_b_q >= CNT_W'(DEPTH));

  assign wr_entry.row   = INDEX_BITS'(row_i);
  assign wr_entry.col   = INDEX_BITS'(col_i);
  assign wr_entry.value = value_i;

  // stores: written on loads, read at the next walk index so heads are ready each cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && !full_a) begin
      mem_a[cnt_a_q[ADDR_W-1:0]] <= wr_entry;
    end
    if (cmd_i.wr_b && !full_b) begin
      mem_b[cnt_b_q[ADDR_W-1:0]] <= wr_entry;
    end
    rd_a_q <= mem_a[i_d[ADDR_W-1:0]];
    rd_b_q <= mem_b[j_d[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.clr) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.wr_a) begin
        if (full_a) ovf_q <= 1'b1;
        else        cnt_a_q <= cnt_a_q + CNT_W'(1);
      end
      if (cmd_i.wr_b) begin
        if (full_b) ovf_q <= 1'b1;
        else        cnt_b_q <= cnt_b_q + CNT_W'(1);
      end
    end
  end

  // head compare
  always_comb begin
    a_av    = (i_q < cnt_a_q);
    b_av    = (j_q < cnt_b_q);
    row_lt  = (rd_a_q.row < rd_b_q.row);
    row_eq  = (rd_a_q.row == rd_b_q.row);
    col_lt  = (rd_a_q.col < rd_b_q.col);
    col_eq  = (rd_a_q.col == rd_b_q.col);
    both    = a_av && b_av && row_eq && col_eq;
    a_first = a_av && (!b_av || row_lt || (row_eq && col_lt));
    b_first = b_av && !a_first && !both;
    take_a  = a_first || both;
    take_b  = b_first || both;
    i_nxt   = i_q + CNT_W'(take_a);
    j_nxt   = j_q + CNT_W'(take_b);
    pick_last = (i_nxt >= cnt_a_q) && (j_nxt >= cnt_b_q);
    pick      = a_first ? rd_a_q : rd_b_q;
    if (both) begin
      pick_val = {rd_a_q.value[VAL_W-1], rd_a_q.value}
               + {rd_b_q.value[VAL_W-1], rd_b_q.value};
    end else begin
      pick_val = {pick.value[VAL_W-1], pick.value};
    end
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.start) begin
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.step) begin
      i_d = i_nxt;
      j_d = j_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      last_q    <= pick_last;
      out_ovf_q <= ovf_q;
      if (!a_av && !b_av) begin
        // both stores empty
        out_row_q <= '0;
        out_col_q <= '0;
        out_val_q <= '0;
        empty_q   <= 1'b1;
      end else begin
        out_row_q <= 16'(pick.row);
        out_col_q <= 16'(pick.col);
        out_val_q <= pick_val;
        empty_q   <= 1'b0;
      end
    end
  end

  assign sts_o.last   = pick_last;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_value_o  = $signed(out_val_q);
  assign last_o       = last_q;
  assign empty_res_o  = empty_q;
  assign overflow_o   = out_ovf_q;

endmodule
`default_nettype wire

// ----- design/scma_ctrl.sv -----
// Controller: idle/merge state machine and result word valid flag.
`timescale 1ns / 1ps
`default_nettype none
module scma_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     action_i,
  output      logic           in_ready_o,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  input  wire scma_pkg::sts_t sts_i,
  output      scma_pkg::cmd_t cmd_o
);
  import scma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    accept;
  action_e act;

  assign act    = action_e'(action_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_LOAD_A: cmd_o.wr_a = 1'b1;
            ACT_LOAD_B: cmd_o.wr_b = 1'b1;
            ACT_MERGE: begin
              cmd_o.start = 1'b1;
              state_d     = ST_RUN;
            end
            ACT_CLEAR:  cmd_o.clr  = 1'b1;
            default:    cmd_o      = '0;
          endcase
        end
      end
      ST_RUN: begin
        // one result word per cycle while the output register can take it
        if (!out_valid_q || out_ready_i) begin
          cmd_o.step  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- design/sparse_coo_matrix_add.sv -----
// Sparse COO matrix adder: two coordinate stores merged into one sorted result stream.
//
// Input channel in_i carries words with an action: load A, load B, merge, clear.
// Load and clear words leave the block idle; in_i.ready stays high while idle.
// A merge word walks both stores (up to 32 entries each) and emits one result
// word per merged element on out_o, last set on the final one. Coincident
// coordinates give one word with the 17-bit sum; an empty pair of stores gives
// one word with empty_res and last set. A load into a full store is dropped and
// sets the sticky overflow flag carried in every result word until a clear.
// The merge word starts the walk: the store heads are read, then the first result
// word is registered in the output register. A merge holds in_i.ready low until
// its final word is stepped; the walk advances one word per cycle while out_o is
// not stalled, through the single registered read port of each store. A stall
// on out_o freezes the walk; the final word sits in the output register while
// new input words are taken. Reset clears both counts, the overflow flag and the
// output valid; store contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none
module sparse_coo_matrix_add (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  scma_in_if.sink   in_i,
  scma_out_if.source out_o
);
  import scma_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .action_i    (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .row_i       (in_i.row),
    .col_i       (in_i.col),
    .value_i     (in_i.value),
    .sts_o       (sts),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .out_value_o (out_o.out_value),
    .last_o      (out_o.last),
    .empty_res_o (out_o.empty_res),
    .overflow_o  (out_o.overflow)
  );

  // a merge blocks input words in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.action == ACT_MERGE) |=> !in_i.ready)
    else $error("input taken right after merge start");

  // an empty result is always the final word of its merge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.empty_res) |-> out_o.last)
    else $error("empty result without last");

  // the walk only steps when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !cmd.step)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ----- test/scma_tb_checker.sv -----
// Checker for the COO adder: tracks both stores, predicts merge results, compares output words.
`timescale 1ns / 1ps
module scma_tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  scma_in_if   in_mon,
  scma_out_if  out_mon,
  input  logic end_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   dropped_o
);
  import scma_pkg::*;

  typedef struct packed {
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [16:0] value;
    logic               last;
    logic               empty;
    logic               ovf;
  } res_word_t;

  entry_t      list_a [DEPTH];
  entry_t      list_b [DEPTH];
  int          used_a;
  int          used_b;
  logic        ovf_sticky;
  res_word_t   merged_due [$];
  res_word_t   held;
  bit          held_valid;
  bit          closed;

  task automatic flag_error(string what);
    fail_count_o++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  function automatic logic signed [16:0] widen(logic [15:0] v);
    return {v[15], v};
  endfunction

  // The last word of a merge is only known once the walk ends, so hold one back.
  function automatic void stage(logic [15:0] r, logic [15:0] c, logic signed [16:0] v);
    if (held_valid) merged_due.push_back(held);
    held = '{row: r, col: c, value: v, last: 1'b0, empty: 1'b0, ovf: ovf_sticky};
    held_valid = 1'b1;
  endfunction

  function automatic void take_load(bit into_b, logic [15:0] r, logic [15:0] c,
                                    logic [15:0] v);
    if (!into_b) begin
      if (used_a >= DEPTH) begin
        ovf_sticky = 1'b1;
        dropped_o++;
      end else begin
        list_a[used_a] = '{row: r, col: c, value: v};
        used_a++;
      end
    end else begin
      if (used_b >= DEPTH) begin
        ovf_sticky = 1'b1;
        dropped_o++;
      end else begin
        list_b[used_b] = '{row: r, col: c, value: v};
        used_b++;
      end
    end
  endfunction

  function automatic void predict_merge();
    int          ia;
    int          ib;
    logic [31:0] ka;
    logic [31:0] kb;
    ia = 0;
    ib = 0;
    if (used_a == 0 && used_b == 0) begin
      merged_due.push_back('{row: '0, col: '0, value: '0, last: 1'b1, empty: 1'b1,
                             ovf: ovf_sticky});
      return;
    end
    held_valid = 1'b0;
    // Only the current heads are compared, so unsorted stores walk the same way.
    while (ia < used_a && ib < used_b) begin
      ka = {list_a[ia].row, list_a[ia].col};
      kb = {list_b[ib].row, list_b[ib].col};
      if (ka < kb) begin
        stage(list_a[ia].row, list_a[ia].col, widen(list_a[ia].value));
        ia++;
      end else if (ka > kb) begin
        stage(list_b[ib].row, list_b[ib].col, widen(list_b[ib].value));
        ib++;
      end else begin
        stage(list_a[ia].row, list_a[ia].col,
              widen(list_a[ia].value) + widen(list_b[ib].value));
        ia++;
        ib++;
      end
    end
    while (ia < used_a) begin
      stage(list_a[ia].row, list_a[ia].col, widen(list_a[ia].value));
      ia++;
    end
    while (ib < used_b) begin
      stage(list_b[ib].row, list_b[ib].col, widen(list_b[ib].value));
      ib++;
    end
    held.last = 1'b1;
    merged_due.push_back(held);
  endfunction

  task automatic check_word();
    res_word_t want;
    if (merged_due.size() == 0) begin
      flag_error($sformatf("result word row %h col %h with nothing expected",
                           out_mon.out_row, out_mon.out_col));
      return;
    end
    want = merged_due.pop_front();
    checked_o++;
    if (out_mon.out_row !== want.row)
      flag_error($sformatf("out_row %h, expected %h", out_mon.out_row, want.row));
    if (out_mon.out_col !== want.col)
      flag_error($sformatf("out_col %h, expected %h", out_mon.out_col, want.col));
    if (out_mon.out_value !== want.value)
      flag_error($sformatf("out_value %0d, expected %0d", out_mon.out_value, want.value));
    if (out_mon.last !== want.last)
      flag_error($sformatf("last %b, expected %b", out_mon.last, want.last));
    if (out_mon.empty_res !== want.empty)
      flag_error($sformatf("empty_res %b, expected %b", out_mon.empty_res, want.empty));
    if (out_mon.overflow !== want.ovf)
      flag_error($sformatf("overflow %b, expected %b", out_mon.overflow, want.ovf));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_a = 0;
      used_b = 0;
      ovf_sticky = 1'b0;
      merged_due.delete();
      pending_o <= 0;
    end else begin
      // outputs first: a merge taken at this edge cannot have produced a word yet
      if (out_mon.valid && out_mon.ready) check_word();
      if (in_mon.valid && in_mon.ready) begin
        case (action_e'(in_mon.action))
          ACT_LOAD_A: take_load(1'b0, in_mon.row, in_mon.col, in_mon.value);
          ACT_LOAD_B: take_load(1'b1, in_mon.row, in_mon.col, in_mon.value);
          ACT_MERGE:  predict_merge();
          ACT_CLEAR: begin
            used_a = 0;
            used_b = 0;
            ovf_sticky = 1'b0;
          end
          default: ;
        endcase
      end
      if (end_i && !closed) begin
        closed = 1'b1;
        if (merged_due.size() != 0)
          flag_error($sformatf("%0d result words never arrived", merged_due.size()));
      end
      pending_o <= merged_due.size();
    end
  end

endmodule

// ----- test/tb_sparse_coo_matrix_add.sv -----
// Testbench top for the COO adder: clock, reset, word stimulus, output back-pressure, verdict.
`timescale 1ns / 1ps
module tb_sparse_coo_matrix_add;
  import scma_pkg::*;

  localparam int RANDOM_WORDS = 120;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_LIMIT  = 20000;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic end_check = 1'b0;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_req;
  int   words_sent;
  int   merges_sent;
  int   fail_count;
  int   pending;
  int   checked;
  int   dropped;

  scma_in_if  word_in ();
  scma_out_if word_out ();

  sparse_coo_matrix_add dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_in),
    .out_o  (word_out)
  );

  scma_tb_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (word_in),
    .out_mon      (word_out),
    .end_i        (end_check),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .dropped_o    (dropped)
  );

  always #4 clk_i = ~clk_i;

  task automatic offer_word(action_e act, logic [15:0] r, logic [15:0] c, logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      word_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in.valid  <= 1'b1;
    word_in.action <= act;
    word_in.row    <= r;
    word_in.col    <= c;
    word_in.value  <= v;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
    words_sent++;
    if (act == ACT_MERGE) merges_sent++;
  endtask

  // merge and clear ignore the element fields, so fill them with junk
  task automatic offer_ctrl(action_e act);
    offer_word(act, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Row-major sorted loads into both stores, drawn from one ascending key walk
  // so that coordinates often coincide.
  task automatic load_pair(int na, int nb);
    logic [31:0] key;
    logic [15:0] va;
    int          ia;
    int          ib;
    int          pick;
    bit          wide;
    key  = ($urandom_range(3) == 0) ? 32'd0 : ($urandom & 32'h7FFF_FFFF);
    wide = 1'($urandom_range(1));
    ia   = 0;
    ib   = 0;
    while (ia < na || ib < nb) begin
      key += wide ? $urandom_range(1, 1 << 24) : $urandom_range(1, 3);
      if (ia == na) pick = 1;
      else if (ib == nb) pick = 0;
      else pick = $urandom_range(2);
      va = pick_value();
      if (pick != 1) begin
        offer_word(ACT_LOAD_A, key[31:16], key[15:0], va);
        ia++;
      end
      if (pick != 0) begin
        offer_word(ACT_LOAD_B, key[31:16], key[15:0],
                   ($urandom_range(3) == 0) ? -va : pick_value());
        ib++;
      end
    end
  endtask

  task automatic random_round();
    int na;
    int nb;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 6))
        offer_word(action_e'($urandom_range(3)), 16'($urandom), 16'($urandom),
                   16'($urandom));
    end else begin
      if ($urandom_range(3) != 0) offer_ctrl(ACT_CLEAR);
      if ($urandom_range(9) == 0) begin
        na = $urandom_range(28, 34);
        nb = $urandom_range(28, 34);
      end else begin
        na = $urandom_range(0, 6);
        nb = $urandom_range(0, 6);
      end
      load_pair(na, nb);
      offer_ctrl(ACT_MERGE);
      if ($urandom_range(3) == 0) offer_ctrl(ACT_MERGE);
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    word_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        word_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      word_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stim
    int base;
    int waited;
    word_in.valid  = 1'b0;
    word_in.action = ACT_LOAD_A;
    word_in.row    = '0;
    word_in.col    = '0;
    word_in.value  = '0;
    send_idle_pct  = 36;
    recv_idle_pct  = 49;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_ctrl(ACT_MERGE);                                 // both stores empty
    offer_word(ACT_LOAD_A, 16'h0000, 16'h0000, 16'h8000);
    offer_word(ACT_LOAD_B, 16'h0000, 16'h0000, 16'h8000);  // most negative sum
    offer_word(ACT_LOAD_A, 16'h0000, 16'h0005, 16'h0000);
    offer_word(ACT_LOAD_B, 16'h0000, 16'h0005, 16'h0000);  // zero sum still emitted
    offer_word(ACT_LOAD_A, 16'h0001, 16'h0002, 16'h7FFF);
    offer_word(ACT_LOAD_B, 16'h0001, 16'h0002, 16'h7FFF);  // most positive sum
    offer_word(ACT_LOAD_A, 16'h0007, 16'h0003, 16'h0064);
    offer_word(ACT_LOAD_B, 16'h0007, 16'h0009, 16'hFFFB);
    offer_word(ACT_LOAD_A, 16'h8000, 16'h0000, 16'hFFFF);
    offer_word(ACT_LOAD_B, 16'hFFFF, 16'hFFFF, 16'h0001);
    offer_ctrl(ACT_MERGE);
    offer_ctrl(ACT_MERGE);                                 // stores unchanged by a merge
    offer_word(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_ctrl(ACT_MERGE);
    offer_word(ACT_LOAD_A, 16'h0005, 16'h0005, 16'h0001);
    offer_word(ACT_LOAD_A, 16'h0002, 16'h0002, 16'h0002);  // A out of order
    offer_word(ACT_LOAD_B, 16'h0003, 16'h0003, 16'h0003);
    offer_ctrl(ACT_MERGE);
    offer_ctrl(ACT_CLEAR);
    offer_word(ACT_LOAD_B, 16'hAAAA, 16'h5555, 16'h5A5A);
    offer_word(ACT_LOAD_B, 16'hAAAA, 16'h5556, 16'hA5A5);
    offer_ctrl(ACT_MERGE);                                 // B alone

    base = words_sent;
    while (words_sent < base + RANDOM_WORDS / 3) random_round();
    send_idle_pct = 49;
    recv_idle_pct = 36;
    while (words_sent < base + 2 * RANDOM_WORDS / 3) random_round();
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // long output stall with a full A store: the merges back up the input
    hold_req = 1'b1;
    offer_ctrl(ACT_CLEAR);
    load_pair(33, 6);
    repeat (3) offer_ctrl(ACT_MERGE);
    while (words_sent < base + RANDOM_WORDS) random_round();
    word_in.valid <= 1'b0;

    waited = 0;
    @(posedge clk_i);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (16) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Run covered %0d input words, %0d of them merges; %0d loads hit a full store.",
             words_sent, merges_sent, dropped);
    $display("%0d result words compared, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("sparse_coo_matrix_add test passed");
    end else begin
      $display("sparse_coo_matrix_add test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: run did not finish.");
    $display("sparse_coo_matrix_add test failed");
    $finish;
  end

endmodule
